>>> rtl/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Shared types and constants for the particle bounce block: fixed-point
// scales, widths, register indexes, command codes and sequencer states.
// ----------------------------------------------------------------------------
package pbc_pkg;

    // fixed-point scale of a unit vector
    localparam int FRAC_SCALE = 1000000;

    localparam int POS_W  = 24;
    localparam int DIR_W  = 21;
    localparam int EL_W   = 16;
    localparam int SPD_W  = 16;
    localparam int RAD_W  = 23;
    localparam int TR_W   = 35;   // tentative point, signed
    localparam int MAG_W  = 35;   // magnitudes going into normalization
    localparam int UNIT_W = 20;   // unit component magnitude, up to FRAC_SCALE
    localparam int DOT_W  = 42;   // dot product, signed
    localparam int ACC_W  = 50;   // sum of two squares
    localparam int PROD_W = 62;   // products feeding a division
    localparam int ROOT_W = 32;
    localparam int ALU_W  = 64;

    localparam int MUL_STEPS  = 32;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 6;

    localparam logic [ALU_W-1:0] FRAC_W64  = ALU_W'(FRAC_SCALE);
    localparam logic [ALU_W-1:0] UNIT_NUM  = ALU_W'(FRAC_SCALE) * ALU_W'(64);
    localparam logic [ALU_W-1:0] FRAC_SQ   = ALU_W'(FRAC_SCALE) * ALU_W'(FRAC_SCALE);
    localparam logic [ALU_W-1:0] SQRT_BIT0 = ALU_W'(1) << 62;

    localparam logic [SPD_W-1:0] SPEED_RST  = 16'd21;
    localparam logic [RAD_W-1:0] RADIUS_RST = 23'd2000000;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 23;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b1;

    // request commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_PLACE = 1'b1;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_U_NORM,
        ST_U_SQA,
        ST_U_SQB,
        ST_U_SQRT,
        ST_U_NUMA,
        ST_U_DIVA,
        ST_U_NUMB,
        ST_U_DIVB,
        ST_U_STORE,
        ST_D_ELM,
        ST_D_SPM,
        ST_D_DIV,
        ST_B_CHECK,
        ST_B_SQA,
        ST_B_SQB,
        ST_B_RSQ,
        ST_R_DOT0,
        ST_R_DOT1,
        ST_R_MUL,
        ST_R_DIV,
        ST_DONE
    } pbc_state_t;

endpackage

>>> rtl/particle_bounce_in_circle_step.sv
// ----------------------------------------------------------------------------
// particle_bounce_in_circle_step
// One particle moving inside a circle at the origin, reflecting at the rim.
// ----------------------------------------------------------------------------
// A place request loads position and raw direction and answers through the
// output register without using the serial unit. A tick request normalizes
// the direction, advances a tentative point by unit direction * elapsed *
// speed / 1e6, tests it against the radius and either takes it or keeps the
// position and reverses the direction's component along the inward normal.
// Multiplies, divides and square roots all go through one bit-serial unit,
// and normalization brings each vector into range by single-bit shifts; a
// bounce adds a unitized rim normal and the reflection. One request is in work
// at a time; the output register lets a new request in while the last result
// still waits. Configuration writes take effect at once and belong to idle
// periods.
module particle_bounce_in_circle_step
    import pbc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    command,
    input  logic [EL_W-1:0]         elapsed,
    input  logic signed [POS_W-1:0] place_re,
    input  logic signed [POS_W-1:0] place_im,
    input  logic signed [DIR_W-1:0] place_dir_re,
    input  logic signed [DIR_W-1:0] place_dir_im,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [POS_W-1:0] pos_re,
    output logic signed [POS_W-1:0] pos_im,
    output logic signed [DIR_W-1:0] dir_re,
    output logic signed [DIR_W-1:0] dir_im,
    output logic                    bounced
);

    // magnitude helpers
    function automatic logic [DIR_W-1:0] mag_dir(input logic signed [DIR_W-1:0] v);
        mag_dir = v[DIR_W-1] ? DIR_W'(-v) : DIR_W'(v);
    endfunction

    function automatic logic [TR_W-1:0] mag_tr(input logic signed [TR_W-1:0] v);
        mag_tr = v[TR_W-1] ? TR_W'(-v) : TR_W'(v);
    endfunction

    function automatic logic [DOT_W-1:0] mag_dot(input logic signed [DOT_W-1:0] v);
        mag_dot = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
    endfunction

    localparam logic [TR_W-1:0] FAR_LIMIT = TR_W'(1) << 23;
    localparam logic signed [24:0] SAT_HI = 25'sd1000000;
    localparam logic signed [24:0] SAT_LO = -25'sd1000000;

    pbc_state_t state_reg;
    pbc_state_t state_next;

    // configuration
    logic [SPD_W-1:0] speed_reg;
    logic [RAD_W-1:0] radius_reg;

    // particle state
    logic signed [POS_W-1:0] posr_reg;
    logic signed [POS_W-1:0] posi_reg;
    logic signed [DIR_W-1:0] dirr_reg;
    logic signed [DIR_W-1:0] diri_reg;

    // working registers of one tick
    logic [EL_W-1:0]         el_reg;
    logic [MAG_W-1:0]        ma_reg;
    logic [MAG_W-1:0]        mb_reg;
    logic                    sa_reg;
    logic                    sb_reg;
    logic                    upass_reg;   // 0: direction, 1: rim normal
    logic [UNIT_W-1:0]       xa_reg;
    logic [UNIT_W-1:0]       xb_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [ROOT_W-1:0]       m_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic signed [DIR_W-1:0] ur_reg;
    logic signed [DIR_W-1:0] ui_reg;
    logic signed [DIR_W-1:0] nr_reg;
    logic signed [DIR_W-1:0] ni_reg;
    logic signed [TR_W-1:0]  trr_reg;
    logic signed [TR_W-1:0]  tri_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic                    comp_reg;    // 0: real part, 1: imaginary part
    logic                    bounced_reg;
    logic                    wait_reg;    // serial unit started, result pending

    // output stage
    logic                    out_valid_reg;
    logic signed [POS_W-1:0] pos_re_reg;
    logic signed [POS_W-1:0] pos_im_reg;
    logic signed [DIR_W-1:0] dir_re_reg;
    logic signed [DIR_W-1:0] dir_im_reg;
    logic                    bounced_out_reg;

    // serial unit
    alu_req_t         alu_req;
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic             alu_done;
    logic [ALU_W-1:0] alu_res;

    // per component selections and derived values
    logic signed [DIR_W-1:0] u_c;
    logic signed [DIR_W-1:0] n_c;
    logic signed [POS_W-1:0] pos_c;
    logic [MAG_W-1:0]        mx;
    logic                    in_fire;
    logic                    out_load;
    logic                    far;
    logic signed [TR_W-1:0]  q_disp;
    logic signed [TR_W-1:0]  tr_new;
    logic signed [24:0]      q_ref;
    logic signed [24:0]      nv;
    logic signed [DIR_W-1:0] nv_sat;
    logic signed [DOT_W-1:0] prod_s;
    logic                    dot_neg;
    logic signed [DOT_W-1:0] dot_term;
    logic [UNIT_W-1:0]       x_clamp;
    logic signed [DIR_W-1:0] ua_s;
    logic signed [DIR_W-1:0] ub_s;

    assign u_c   = comp_reg ? ui_reg : ur_reg;
    assign n_c   = comp_reg ? ni_reg : nr_reg;
    assign pos_c = comp_reg ? posi_reg : posr_reg;
    assign mx    = (ma_reg > mb_reg) ? ma_reg : mb_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // far point counts as beyond the rim without squaring
    assign far = (mag_tr(trr_reg) > FAR_LIMIT) || (mag_tr(tri_reg) > FAR_LIMIT);

    // displacement truncated toward zero, sign of the unit component
    assign q_disp = $signed({1'b0, alu_res[TR_W-2:0]});
    assign tr_new = TR_W'(pos_c) + (u_c[DIR_W-1] ? -q_disp : q_disp);

    // reflected component, saturated to a unit
    assign q_ref  = $signed({2'b0, alu_res[22:0]});
    assign nv     = 25'(u_c) - ((dot_reg[DOT_W-1] ^ n_c[DIR_W-1]) ? -q_ref : q_ref);
    always_comb
    begin
        priority if (nv > SAT_HI)
            nv_sat = DIR_W'(SAT_HI);
        else if (nv < SAT_LO)
            nv_sat = DIR_W'(SAT_LO);
        else
            nv_sat = DIR_W'(nv);
    end

    // signed dot product terms
    assign prod_s   = $signed({1'b0, alu_res[DOT_W-2:0]});
    assign dot_neg  = (state_reg == ST_R_DOT0) ? (ur_reg[DIR_W-1] ^ nr_reg[DIR_W-1])
                                               : (ui_reg[DIR_W-1] ^ ni_reg[DIR_W-1]);
    assign dot_term = dot_neg ? -prod_s : prod_s;

    // unit component clamp and sign
    assign x_clamp = (alu_res > FRAC_W64) ? UNIT_W'(FRAC_SCALE) : alu_res[UNIT_W-1:0];
    assign ua_s    = sa_reg ? -$signed({1'b0, xa_reg}) : $signed({1'b0, xa_reg});
    assign ub_s    = sb_reg ? -$signed({1'b0, xb_reg}) : $signed({1'b0, xb_reg});

    pbc_serial_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (alu_a),
        .b      (alu_b),
        .done   (alu_done),
        .result (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencer: next state and serial unit operands
    always_comb
    begin
        state_next  = state_reg;
        alu_req     = '{start: 1'b0, op: ALU_MUL};
        alu_a       = '0;
        alu_b       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = (command == CMD_PLACE) ? ST_DONE : ST_U_NORM;
            end
            ST_U_NORM:
            begin
                if ((ma_reg == '0) && (mb_reg == '0))
                    state_next = ST_U_STORE;
                else if ((mx[MAG_W-1:24] == '0) && mx[23])
                    state_next = ST_U_SQA;
            end
            ST_U_SQA:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = ALU_W'(ma_reg);
                alu_b   = ALU_W'(ma_reg);
                if (alu_done)
                    state_next = ST_U_SQB;
            end
            ST_U_SQB:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = ALU_W'(mb_reg);
                alu_b   = ALU_W'(mb_reg);
                if (alu_done)
                    state_next = ST_U_SQRT;
            end
            ST_U_SQRT:
            begin
                alu_req = '{start: !wait_reg, op: ALU_SQRT};
                alu_a   = ALU_W'({acc_reg, 12'b0});
                if (alu_done)
                    state_next = ST_U_NUMA;
            end
            ST_U_NUMA:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = UNIT_NUM;
                alu_b   = ALU_W'(ma_reg);
                if (alu_done)
                    state_next = ST_U_DIVA;
            end
            ST_U_DIVA:
            begin
                alu_req = '{start: !wait_reg, op: ALU_DIV};
                alu_a   = ALU_W'(prod_reg);
                alu_b   = ALU_W'(m_reg);
                if (alu_done)
                    state_next = ST_U_NUMB;
            end
            ST_U_NUMB:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = UNIT_NUM;
                alu_b   = ALU_W'(mb_reg);
                if (alu_done)
                    state_next = ST_U_DIVB;
            end
            ST_U_DIVB:
            begin
                alu_req = '{start: !wait_reg, op: ALU_DIV};
                alu_a   = ALU_W'(prod_reg);
                alu_b   = ALU_W'(m_reg);
                if (alu_done)
                    state_next = ST_U_STORE;
            end
            ST_U_STORE:
            begin
                state_next = upass_reg ? ST_R_DOT0 : ST_D_ELM;
            end
            ST_D_ELM:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = ALU_W'(mag_dir(u_c));
                alu_b   = ALU_W'(el_reg);
                if (alu_done)
                    state_next = ST_D_SPM;
            end
            ST_D_SPM:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = ALU_W'(prod_reg);
                alu_b   = ALU_W'(speed_reg);
                if (alu_done)
                    state_next = ST_D_DIV;
            end
            ST_D_DIV:
            begin
                alu_req = '{start: !wait_reg, op: ALU_DIV};
                alu_a   = ALU_W'(prod_reg);
                alu_b   = FRAC_W64;
                if (alu_done)
                    state_next = comp_reg ? ST_B_CHECK : ST_D_ELM;
            end
            ST_B_CHECK:
            begin
                state_next = far ? ST_U_NORM : ST_B_SQA;
            end
            ST_B_SQA:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = ALU_W'(mag_tr(trr_reg));
                alu_b   = ALU_W'(mag_tr(trr_reg));
                if (alu_done)
                    state_next = ST_B_SQB;
            end
            ST_B_SQB:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = ALU_W'(mag_tr(tri_reg));
                alu_b   = ALU_W'(mag_tr(tri_reg));
                if (alu_done)
                    state_next = ST_B_RSQ;
            end
            ST_B_RSQ:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = ALU_W'(radius_reg);
                alu_b   = ALU_W'(radius_reg);
                if (alu_done)
                    state_next = (acc_reg > alu_res[ACC_W-1:0]) ? ST_U_NORM : ST_DONE;
            end
            ST_R_DOT0:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = ALU_W'(mag_dir(ur_reg));
                alu_b   = ALU_W'(mag_dir(nr_reg));
                if (alu_done)
                    state_next = ST_R_DOT1;
            end
            ST_R_DOT1:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = ALU_W'(mag_dir(ui_reg));
                alu_b   = ALU_W'(mag_dir(ni_reg));
                if (alu_done)
                    state_next = ST_R_MUL;
            end
            ST_R_MUL:
            begin
                alu_req = '{start: !wait_reg, op: ALU_MUL};
                alu_a   = ALU_W'(mag_dot(dot_reg));
                alu_b   = ALU_W'(mag_dir(n_c));
                if (alu_done)
                    state_next = ST_R_DIV;
            end
            ST_R_DIV:
            begin
                alu_req = '{start: !wait_reg, op: ALU_DIV};
                alu_a   = ALU_W'({prod_reg, 1'b0});
                alu_b   = FRAC_SQ;
                if (alu_done)
                    state_next = comp_reg ? ST_DONE : ST_R_MUL;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, configuration and particle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= SPEED_RST;
            radius_reg    <= RADIUS_RST;
            posr_reg      <= '0;
            posi_reg      <= '0;
            dirr_reg      <= '0;
            diri_reg      <= '0;
            wait_reg      <= 1'b0;
            comp_reg      <= 1'b0;
            upass_reg     <= 1'b0;
            bounced_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SPEED:  speed_reg  <= cfg_data[SPD_W-1:0];
                    CFG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                    default:    speed_reg  <= speed_reg;
                endcase
            end

            if (alu_req.start)
                wait_reg <= 1'b1;
            else if (alu_done)
                wait_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        bounced_reg <= 1'b0;
                        comp_reg    <= 1'b0;
                        upass_reg   <= 1'b0;
                        if (command == CMD_PLACE)
                        begin
                            posr_reg <= place_re;
                            posi_reg <= place_im;
                            dirr_reg <= place_dir_re;
                            diri_reg <= place_dir_im;
                        end
                    end
                end
                ST_U_STORE:
                begin
                    comp_reg <= 1'b0;
                end
                ST_D_DIV:
                begin
                    if (alu_done)
                        comp_reg <= !comp_reg;
                end
                ST_B_CHECK:
                begin
                    if (far)
                        upass_reg <= 1'b1;
                end
                ST_B_RSQ:
                begin
                    if (alu_done)
                    begin
                        if (acc_reg > alu_res[ACC_W-1:0])
                        begin
                            upass_reg <= 1'b1;
                        end
                        else
                        begin
                            // inside the rim: take the tentative point
                            posr_reg <= trr_reg[POS_W-1:0];
                            posi_reg <= tri_reg[POS_W-1:0];
                            dirr_reg <= ur_reg;
                            diri_reg <= ui_reg;
                        end
                    end
                end
                ST_R_DIV:
                begin
                    if (alu_done)
                    begin
                        comp_reg <= !comp_reg;
                        if (comp_reg)
                        begin
                            diri_reg    <= nv_sat;
                            bounced_reg <= 1'b1;
                        end
                        else
                        begin
                            dirr_reg <= nv_sat;
                        end
                    end
                end
                default:
                begin
                    comp_reg <= comp_reg;
                end
            endcase
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                el_reg <= elapsed;
                ma_reg <= MAG_W'(mag_dir(dirr_reg));
                mb_reg <= MAG_W'(mag_dir(diri_reg));
                sa_reg <= dirr_reg[DIR_W-1];
                sb_reg <= diri_reg[DIR_W-1];
            end
            ST_U_NORM:
            begin
                // bring the larger magnitude into [2^23, 2^24)
                priority if ((ma_reg == '0) && (mb_reg == '0))
                begin
                    xa_reg <= '0;
                    xb_reg <= '0;
                end
                else if (mx[MAG_W-1:24] != '0)
                begin
                    ma_reg <= ma_reg >> 1;
                    mb_reg <= mb_reg >> 1;
                end
                else if (!mx[23])
                begin
                    ma_reg <= ma_reg << 1;
                    mb_reg <= mb_reg << 1;
                end
            end
            ST_U_SQA:
            begin
                if (alu_done)
                    acc_reg <= alu_res[ACC_W-1:0];
            end
            ST_U_SQB:
            begin
                if (alu_done)
                    acc_reg <= acc_reg + alu_res[ACC_W-1:0];
            end
            ST_U_SQRT:
            begin
                if (alu_done)
                    m_reg <= alu_res[ROOT_W-1:0];
            end
            ST_U_NUMA, ST_U_NUMB, ST_D_ELM, ST_D_SPM, ST_R_MUL:
            begin
                if (alu_done)
                    prod_reg <= alu_res[PROD_W-1:0];
            end
            ST_U_DIVA:
            begin
                if (alu_done)
                    xa_reg <= x_clamp;
            end
            ST_U_DIVB:
            begin
                if (alu_done)
                    xb_reg <= x_clamp;
            end
            ST_U_STORE:
            begin
                if (upass_reg)
                begin
                    nr_reg <= ua_s;
                    ni_reg <= ub_s;
                end
                else
                begin
                    ur_reg <= ua_s;
                    ui_reg <= ub_s;
                end
            end
            ST_D_DIV:
            begin
                if (alu_done)
                begin
                    if (comp_reg)
                        tri_reg <= tr_new;
                    else
                        trr_reg <= tr_new;
                end
            end
            ST_B_CHECK:
            begin
                // rim normal points inward: unitize the negated point
                ma_reg <= mag_tr(trr_reg);
                mb_reg <= mag_tr(tri_reg);
                sa_reg <= !trr_reg[TR_W-1] && (trr_reg != '0);
                sb_reg <= !tri_reg[TR_W-1] && (tri_reg != '0);
            end
            ST_B_SQA:
            begin
                if (alu_done)
                    acc_reg <= alu_res[ACC_W-1:0];
            end
            ST_B_SQB:
            begin
                if (alu_done)
                    acc_reg <= acc_reg + alu_res[ACC_W-1:0];
            end
            ST_R_DOT0:
            begin
                if (alu_done)
                    dot_reg <= dot_term;
            end
            ST_R_DOT1:
            begin
                if (alu_done)
                    dot_reg <= dot_reg + dot_term;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    pos_re_reg      <= posr_reg;
                    pos_im_reg      <= posi_reg;
                    dir_re_reg      <= dirr_reg;
                    dir_im_reg      <= diri_reg;
                    bounced_out_reg <= bounced_reg;
                end
            end
            default:
            begin
                el_reg <= el_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign pos_re    = pos_re_reg;
    assign pos_im    = pos_im_reg;
    assign dir_re    = dir_re_reg;
    assign dir_im    = dir_im_reg;
    assign bounced   = bounced_out_reg;

endmodule

>>> rtl/pbc_serial_alu.sv
// ----------------------------------------------------------------------------
// pbc_serial_alu
// Shared bit-serial arithmetic unit: shift-add multiply (one multiplier bit
// a cycle), restoring divide and integer square root (one result bit a cycle).
// ----------------------------------------------------------------------------
module pbc_serial_alu
    import pbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  alu_req_t         req,
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output logic             done,
    output logic [ALU_W-1:0] result
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    alu_op_t          op_reg;
    logic [ALU_W-1:0] acc_reg;
    logic [ALU_W-1:0] x_reg;
    logic [ALU_W-1:0] y_reg;
    logic [ALU_W-1:0] rem_reg;

    logic [ALU_W-1:0] sq_trial;
    logic [ALU_W:0]   rem_sh;
    logic [ALU_W:0]   rem_sub;
    logic             div_fit;
    logic [CNT_W-1:0] steps;

    assign sq_trial = x_reg + y_reg;
    assign rem_sh   = {rem_reg, x_reg[ALU_W-1]};
    assign rem_sub  = rem_sh - {1'b0, y_reg};
    assign div_fit  = rem_sh >= {1'b0, y_reg};

    always_comb
    begin
        unique case (req.op)
            ALU_MUL:  steps = CNT_W'(MUL_STEPS - 1);
            ALU_DIV:  steps = CNT_W'(DIV_STEPS - 1);
            ALU_SQRT: steps = CNT_W'(SQRT_STEPS - 1);
            default:  steps = CNT_W'(MUL_STEPS - 1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg <= req.op;
            unique case (req.op)
                ALU_MUL:
                begin
                    acc_reg <= '0;
                    x_reg   <= a;
                    y_reg   <= b;
                end
                ALU_DIV:
                begin
                    rem_reg <= '0;
                    x_reg   <= a;
                    y_reg   <= b;
                end
                ALU_SQRT:
                begin
                    acc_reg <= a;
                    x_reg   <= '0;
                    y_reg   <= SQRT_BIT0;
                end
                default:
                begin
                    acc_reg <= '0;
                    x_reg   <= '0;
                    y_reg   <= '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                ALU_MUL:
                begin
                    if (y_reg[0])
                        acc_reg <= acc_reg + x_reg;
                    x_reg <= x_reg << 1;
                    y_reg <= y_reg >> 1;
                end
                ALU_DIV:
                begin
                    rem_reg <= div_fit ? rem_sub[ALU_W-1:0] : rem_sh[ALU_W-1:0];
                    x_reg   <= {x_reg[ALU_W-2:0], div_fit};
                end
                ALU_SQRT:
                begin
                    if (acc_reg >= sq_trial)
                    begin
                        acc_reg <= acc_reg - sq_trial;
                        x_reg   <= (x_reg >> 1) + y_reg;
                    end
                    else
                    begin
                        x_reg <= x_reg >> 1;
                    end
                    y_reg <= y_reg >> 2;
                end
                default:
                begin
                    x_reg <= x_reg;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == ALU_MUL) ? acc_reg : x_reg;

endmodule

>>> rtl/pbc_checker.sv
// ----------------------------------------------------------------------------
// pbc_checker
// Port-level checks of the particle bounce block, bound to the top level.
// ----------------------------------------------------------------------------
module pbc_checker
    import pbc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    command,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [POS_W-1:0] pos_re,
    input logic signed [POS_W-1:0] pos_im,
    input logic signed [DIR_W-1:0] dir_re,
    input logic signed [DIR_W-1:0] dir_im,
    input logic                    bounced
);

    // one request in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in work");

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pos_re) && $stable(pos_im)
                                       && $stable(dir_re) && $stable(dir_im)))
        else $error("result changed while stalled");

    // reflected direction components lie within the saturated unit range
    a_bounce_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bounced) |-> (dir_re <= 21'sd1000000 && dir_re >= -21'sd1000000
                                    && dir_im <= 21'sd1000000 && dir_im >= -21'sd1000000))
        else $error("reflected direction out of unit range");

    // a place request answers without a bounce
    a_place_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && command && !out_valid) |=> ##1 (out_valid && !bounced))
        else $error("place result missing or marked bounced");

endmodule

bind particle_bounce_in_circle_step pbc_checker u_pbc_checker (.*);
